### rtl/core/rspe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RS(255,223) parity encoder package
// Field arithmetic, generator coefficients, action codes and shared types.
// ----------------------------------------------------------------------------
package rspe_pkg;

   localparam int PARITY_COUNT = 32;
   localparam int HALF_COUNT   = PARITY_COUNT / 2;
   localparam int INDEX_WIDTH  = $clog2(PARITY_COUNT);
   localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = INDEX_WIDTH'(PARITY_COUNT - 1);
   localparam logic [8:0] GF_POLY = 9'h187;

   typedef enum logic [1:0] {
      ACT_ABSORB  = 2'd0,
      ACT_READOUT = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_UNUSED  = 2'd3
   } action_type;

   typedef logic [PARITY_COUNT-1:0][7:0] parity_vec_type;

   typedef struct packed {
      logic       absorb;
      logic       clear;
      logic [7:0] data_byte;
   } lfsr_ctrl_type;

   localparam logic [7:0] GEN_LOG [HALF_COUNT+1] = '{
      8'd0, 8'd249, 8'd59, 8'd66, 8'd4, 8'd43, 8'd126, 8'd251, 8'd97,
      8'd30, 8'd3, 8'd213, 8'd50, 8'd66, 8'd170, 8'd5, 8'd24
   };

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] x;
      logic [7:0] r;
      x = {1'b0, a};
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            r = r ^ x[7:0];
         end
         x = {x[7:0], 1'b0};
         if (x[8]) begin
            x = x ^ GF_POLY;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] gf_alpha_pow(input logic [7:0] e);
      logic [7:0] r;
      r = 8'd1;
      for (int i = 0; i < 255; i++) begin
         if (i < int'(e)) begin
            r = gf_mul(r, 8'd2);
         end
      end
      return r;
   endfunction

   function automatic parity_vec_type gen_coef_table();
      parity_vec_type c;
      int k;
      for (int j = 0; j < PARITY_COUNT; j++) begin
         k = (j <= HALF_COUNT) ? j : PARITY_COUNT - j;
         c[j] = gf_alpha_pow(GEN_LOG[k]);
      end
      return c;
   endfunction

   localparam parity_vec_type GEN_COEF = gen_coef_table();

endpackage
`default_nettype wire

### rtl/core/rspe_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RS(255,223) parity encoder channels
// Valid/ready channels for the request and the parity response.
// ----------------------------------------------------------------------------
interface rspe_req_if
   import rspe_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface rspe_rsp_if
   import rspe_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [7:0]             parity_byte;
   logic [INDEX_WIDTH-1:0] parity_index;
   logic                   last;

   modport source (output valid, output parity_byte, output parity_index, output last,
                   input ready);
   modport sink   (input valid, input parity_byte, input parity_index, input last,
                   output ready);
endinterface
`default_nettype wire

### rtl/core/rspe_lfsr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RS(255,223) parity shift register
// Absorbs one byte per cycle into the 32-entry parity register; clear zeroes it.
// ----------------------------------------------------------------------------
module rspe_lfsr
   import rspe_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire lfsr_ctrl_type  ctrl,
   output parity_vec_type      parity
);

   parity_vec_type parity_ff;
   parity_vec_type parity_in;
   logic [7:0]     feedback;

   assign feedback = ctrl.data_byte ^ parity_ff[0];

   always_comb begin
      parity_in = parity_ff;
      if (ctrl.clear) begin
         parity_in = '0;
      end else if (ctrl.absorb) begin
         for (int j = 0; j < PARITY_COUNT - 1; j++) begin
            parity_in[j] = parity_ff[j+1] ^ gf_mul(feedback, GEN_COEF[j+1]);
         end
         parity_in[PARITY_COUNT-1] = feedback;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= '0;
      end else begin
         parity_ff <= parity_in;
      end
   end

   assign parity = parity_ff;

endmodule
`default_nettype wire

### rtl/core/rspe_drain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RS(255,223) parity readout
// Holds a snapshot of the parities and sends them one per transfer.
// ----------------------------------------------------------------------------
module rspe_drain
   import rspe_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire parity_vec_type  snapshot,
   output logic                 free,
   rspe_rsp_if.source           rsp_bus
);

   parity_vec_type         shift_ff;
   parity_vec_type         shift_in;
   logic [INDEX_WIDTH-1:0] idx_ff;
   logic [INDEX_WIDTH-1:0] idx_in;
   logic                   busy_ff;
   logic                   busy_in;
   logic                   transfer;

   assign transfer = busy_ff & rsp_bus.ready;
   assign free     = ~busy_ff | (transfer & (idx_ff == LAST_INDEX));

   always_comb begin
      shift_in = shift_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (load) begin
         shift_in = snapshot;
         idx_in   = '0;
         busy_in  = 1'b1;
      end else if (transfer) begin
         shift_in = {8'h00, shift_ff[PARITY_COUNT-1:1]};
         idx_in   = idx_ff + 1'b1;
         busy_in  = (idx_ff != LAST_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      shift_ff <= shift_in;
   end

   assign rsp_bus.valid        = busy_ff;
   assign rsp_bus.parity_byte  = shift_ff[0];
   assign rsp_bus.parity_index = idx_ff;
   assign rsp_bus.last         = (idx_ff == LAST_INDEX);

endmodule
`default_nettype wire

### rtl/core/reed_solomon_parity_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RS(255,223) parity encoder
// Systematic CCSDS Reed-Solomon encoder over GF(256), conventional basis.
// ----------------------------------------------------------------------------
// Requests arrive on req_bus with an action and a data byte. Absorb folds the
// byte into the 32-entry parity register, clear zeroes it, and readout sends
// all 32 parities on rsp_bus, entry 0 first, with last set on the final one,
// and then zeroes the register. The unused action code is dropped.
// A request is registered on transfer. An absorb or clear request is processed
// in the next cycle, so one is taken every cycle while no readout is pending.
// A readout copies the parity register into a separate readout buffer, which
// then offers the parities one per cycle while the receiver keeps ready high.
// Absorbing for the next frame continues while the buffer drains; a second
// readout waits in the request register until the buffer has sent its last
// parity.
// When the receiver stalls, the buffer holds its data and a pending readout
// holds off further requests. Reset zeroes the parity register and empties
// the request register and the readout buffer.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder
   import rspe_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   rspe_req_if.sink    req_bus,
   rspe_rsp_if.source  rsp_bus
);

   logic          in_valid_ff;
   logic          in_valid_in;
   action_type    in_action_ff;
   logic [7:0]    in_byte_ff;
   logic          req_transfer;
   logic          fire;
   logic          drain_free;
   lfsr_ctrl_type ctrl;
   parity_vec_type parity;

   assign fire = in_valid_ff & ((in_action_ff != ACT_READOUT) | drain_free);
   assign req_bus.ready = ~in_valid_ff | fire;
   assign req_transfer  = req_bus.valid & req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_transfer) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_transfer) begin
         in_action_ff <= action_type'(req_bus.action);
         in_byte_ff   <= req_bus.data_byte;
      end
   end

   always_comb begin
      ctrl.absorb    = fire & (in_action_ff == ACT_ABSORB);
      ctrl.clear     = fire & ((in_action_ff == ACT_READOUT) |
                               (in_action_ff == ACT_CLEAR));
      ctrl.data_byte = in_byte_ff;
   end

   rspe_lfsr u_lfsr (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .parity (parity)
   );

   rspe_drain u_drain (
      .clock    (clock),
      .reset    (reset),
      .load     (fire & (in_action_ff == ACT_READOUT)),
      .snapshot (parity),
      .free     (drain_free),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RS(255,223) parity encoder testbench
// Sends absorb, readout, clear and unused requests and checks every parity
// symbol. A parity shift register model in the bench predicts each symbol.
// Directed cases come first. Random frames follow under several patterns of
// sender gaps and receiver stalls. The last case is a long receiver hold-off
// that fills the encoder so that it stalls its input.
// ----------------------------------------------------------------------------
module tb;
   import rspe_pkg::*;

   typedef struct {
      logic [7:0]             parity_byte;
      logic [INDEX_WIDTH-1:0] parity_index;
      logic                   last;
   } parity_symbol_type;

   localparam logic [7:0] GEN_LOG_HALF [HALF_COUNT+1] = '{
      8'd0, 8'd249, 8'd59, 8'd66, 8'd4, 8'd43, 8'd126, 8'd251, 8'd97,
      8'd30, 8'd3, 8'd213, 8'd50, 8'd66, 8'd170, 8'd5, 8'd24
   };
   localparam int LIMIT_CYCLES = 400000;

   logic clock;
   logic reset;

   rspe_req_if req_bus ();
   rspe_rsp_if rsp_bus ();

   logic [7:0]        gen_coef [PARITY_COUNT];
   logic [7:0]        parity_model [PARITY_COUNT];
   parity_symbol_type pending_parities [$];
   parity_symbol_type wanted_symbol;
   int                error_count = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                hold_off_cycles = 0;

   reed_solomon_parity_encoder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] shifted;
      acc = 8'h00;
      shifted = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ shifted;
         end
         shifted = {shifted[6:0], 1'b0} ^ (shifted[7] ? 8'h87 : 8'h00);
      end
      return acc;
   endfunction

   task automatic build_generator();
      logic [7:0] coef;
      int         k;
      for (int j = 0; j < PARITY_COUNT; j++) begin
         k = (j <= HALF_COUNT) ? j : PARITY_COUNT - j;
         coef = 8'd1;
         repeat (int'(GEN_LOG_HALF[k])) coef = gf_times(coef, 8'd2);
         gen_coef[j] = coef;
      end
   endtask

   task automatic clear_parities();
      for (int j = 0; j < PARITY_COUNT; j++) begin
         parity_model[j] = 8'h00;
      end
   endtask

   task automatic absorb_byte(input logic [7:0] data);
      logic [7:0] feedback;
      feedback = data ^ parity_model[0];
      for (int j = 0; j < PARITY_COUNT - 1; j++) begin
         parity_model[j] = parity_model[j+1] ^ gf_times(feedback, gen_coef[j+1]);
      end
      parity_model[PARITY_COUNT-1] = feedback;
   endtask

   task automatic queue_parities();
      parity_symbol_type symbol;
      for (int j = 0; j < PARITY_COUNT; j++) begin
         symbol.parity_byte = parity_model[j];
         symbol.parity_index = INDEX_WIDTH'(j);
         symbol.last = (j == PARITY_COUNT - 1);
         pending_parities.push_back(symbol);
      end
      clear_parities();
   endtask

   task automatic predict_request(input action_type act, input logic [7:0] data);
      case (act)
         ACT_ABSORB: begin
            absorb_byte(data);
         end
         ACT_READOUT: begin
            queue_parities();
         end
         ACT_CLEAR: begin
            clear_parities();
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input action_type act, input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.action = act;
      req_bus.data_byte = data;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predict_request(act, data);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         return 8'h00;
      end else if (r == 1) begin
         return 8'hff;
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic send_frame(input int length);
      repeat (length) send_item(ACT_ABSORB, pick_byte());
      send_item(ACT_READOUT, pick_byte());
   endtask

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_bus.ready = 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_parities.size() == 0) begin
            report_mismatch($sformatf("parity %0h at index %0d with none expected",
                                      rsp_bus.parity_byte, rsp_bus.parity_index));
         end else begin
            wanted_symbol = pending_parities.pop_front();
            if (rsp_bus.parity_byte !== wanted_symbol.parity_byte) begin
               report_mismatch($sformatf("parity_byte %0h, expected %0h at index %0d",
                                         rsp_bus.parity_byte, wanted_symbol.parity_byte,
                                         wanted_symbol.parity_index));
            end
            if (rsp_bus.parity_index !== wanted_symbol.parity_index) begin
               report_mismatch($sformatf("parity_index %0d, expected %0d",
                                         rsp_bus.parity_index, wanted_symbol.parity_index));
            end
            if (rsp_bus.last !== wanted_symbol.last) begin
               report_mismatch($sformatf("last %0b, expected %0b at index %0d",
                                         rsp_bus.last, wanted_symbol.last,
                                         wanted_symbol.parity_index));
            end
         end
      end
   end

   task automatic test_readout_after_reset();
      send_item(ACT_READOUT, 8'ha5);
   endtask

   task automatic test_single_symbols();
      send_item(ACT_ABSORB, 8'h01);
      send_item(ACT_READOUT, 8'h00);
      send_item(ACT_ABSORB, 8'hff);
      send_item(ACT_ABSORB, 8'h00);
      send_item(ACT_READOUT, 8'hff);
   endtask

   task automatic test_clear_and_unused();
      send_item(ACT_ABSORB, 8'h5a);
      send_item(ACT_CLEAR, 8'hff);
      send_item(ACT_ABSORB, 8'h80);
      send_item(ACT_UNUSED, 8'h7f);
      send_item(ACT_READOUT, 8'h01);
   endtask

   task automatic test_back_to_back_readout();
      send_item(ACT_ABSORB, 8'h33);
      send_item(ACT_READOUT, 8'h00);
      send_item(ACT_READOUT, 8'h00);
   endtask

   task automatic test_random_frames(input int item_count);
      int sent;
      int r;
      int length;
      sent = 0;
      while (sent < item_count) begin
         r = $urandom_range(99);
         if (r < 6) begin
            send_item(ACT_UNUSED, pick_byte());
            sent++;
         end else if (r < 14) begin
            send_item(ACT_CLEAR, pick_byte());
            sent++;
         end else if (r < 20) begin
            send_item(ACT_READOUT, pick_byte());
            sent++;
         end else begin
            length = (r < 30) ? $urandom_range(17, 48) : $urandom_range(1, 12);
            send_frame(length);
            sent += length + 1;
         end
      end
   endtask

   task automatic test_long_stall();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 300;
      send_frame(6);
      send_frame(6);
      send_frame(6);
      send_frame(8);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.action = ACT_ABSORB;
      req_bus.data_byte = 8'h00;
      rsp_bus.ready = 1'b0;
      reset = 1'b1;
      build_generator();
      clear_parities();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_readout_after_reset();
      test_single_symbols();
      test_clear_and_unused();
      test_back_to_back_readout();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_frames(25);
      send_idle_pct = 65;
      recv_stall_pct = 0;
      test_random_frames(25);
      send_idle_pct = 0;
      recv_stall_pct = 65;
      test_random_frames(25);
      send_idle_pct = 29;
      recv_stall_pct = 29;
      test_random_frames(25);

      test_long_stall();

      req_bus.valid = 1'b0;
      while (pending_parities.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 10);
      $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
